// ----- rtl/kacc_pkg.sv -----
// Package for the keypad alarm clock controller.
// Constants, key codes, mode codes and the structs passed between blocks.
// No dependencies.
`default_nettype none
package kacc_pkg;

    localparam int unsigned TICK_W   = 10;
    localparam int unsigned TIME_W   = 6;
    localparam int unsigned ENTRY_W  = 16;
    localparam int unsigned KEY_W    = 8;
    localparam int unsigned RESULT_W = 32;

    localparam logic [TICK_W-1:0] RESET_TICKS = 10'd200;
    localparam logic [7:0]        TIME_MAX    = 8'd59;

    localparam logic [KEY_W-1:0] KEY_ZERO = 8'd48;
    localparam logic [KEY_W-1:0] KEY_NINE = 8'd57;
    localparam logic [KEY_W-1:0] KEY_A    = 8'h41;
    localparam logic [KEY_W-1:0] KEY_B    = 8'h42;
    localparam logic [KEY_W-1:0] KEY_C    = 8'h43;
    localparam logic [KEY_W-1:0] KEY_D    = 8'h44;
    localparam logic [KEY_W-1:0] KEY_E    = 8'h45;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_KEY  = 1'b1;

    // Strobes for one item that reaches the update logic
    typedef struct packed {
        logic             tick;
        logic             key;
        logic [KEY_W-1:0] key_code;
    } item_ctl_t;

    // Time load from a committed set-time entry
    typedef struct packed {
        logic              load;
        logic [TIME_W-1:0] minutes;
        logic [TIME_W-1:0] seconds;
    } time_load_t;

    // Clock state after the current item
    typedef struct packed {
        logic [TIME_W-1:0] minutes;
        logic [TIME_W-1:0] seconds;
    } clock_view_t;

    // Keypad and alarm status after the current item
    typedef struct packed {
        logic               match;
        logic               armed;
        logic               blink;
        logic               show_entry;
        logic [ENTRY_W-1:0] entry;
    } panel_view_t;

endpackage
`default_nettype wire

// ----- rtl/kacc_clock.sv -----
// Minutes:seconds timekeeper with tick prescaler for the alarm clock controller.
// Depends on kacc_pkg.
`default_nettype none
module kacc_clock (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  kacc_pkg::item_ctl_t       item,
    input  wire  [kacc_pkg::TICK_W-1:0] ticks_per_second,
    input  kacc_pkg::time_load_t      time_load,
    output kacc_pkg::clock_view_t     clock_next
);
    import kacc_pkg::*;

    logic [TICK_W-1:0] prescale_reg, prescale_next;
    logic [TIME_W-1:0] seconds_reg, seconds_next;
    logic [TIME_W-1:0] minutes_reg, minutes_next;
    logic [TICK_W-1:0] prescale_inc;

    assign prescale_inc = prescale_reg + 1'b1;

    always_comb begin
        prescale_next = prescale_reg;
        seconds_next  = seconds_reg;
        minutes_next  = minutes_reg;
        if (item.tick) begin
            // a rate of zero passes every tick, like a rate of one
            if (prescale_inc >= ticks_per_second) begin
                prescale_next = '0;
                if ({2'b00, seconds_reg} >= TIME_MAX) begin
                    seconds_next = '0;
                    if ({2'b00, minutes_reg} >= TIME_MAX) begin
                        minutes_next = '0;
                    end else begin
                        minutes_next = minutes_reg + 1'b1;
                    end
                end else begin
                    seconds_next = seconds_reg + 1'b1;
                end
            end else begin
                prescale_next = prescale_inc;
            end
        end else if (time_load.load) begin
            // prescaler keeps its count
            minutes_next = time_load.minutes;
            seconds_next = time_load.seconds;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            seconds_reg  <= '0;
            minutes_reg  <= '0;
        end else begin
            prescale_reg <= prescale_next;
            seconds_reg  <= seconds_next;
            minutes_reg  <= minutes_next;
        end
    end

    assign clock_next.minutes = minutes_next;
    assign clock_next.seconds = seconds_next;

endmodule
`default_nettype wire

// ----- rtl/kacc_keypad.sv -----
// Key decoder, entry register, mode sequencing and alarm for the clock controller.
// Depends on kacc_pkg; takes the updated clock time from kacc_clock.
`default_nettype none
module kacc_keypad (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  kacc_pkg::item_ctl_t   item,
    input  kacc_pkg::clock_view_t clock_next,
    output kacc_pkg::time_load_t  time_load,
    output kacc_pkg::panel_view_t panel_next
);
    import kacc_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_COMMIT    = 3'd1,
        MODE_CLEAR     = 3'd2,
        MODE_TOGGLE    = 3'd3,
        MODE_SET_TIME  = 3'd4,
        MODE_SET_ALARM = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        SET_IDLE  = 2'd0,
        SET_TIME  = 2'd1,
        SET_ALARM = 2'd2
    } set_mode_t;

    mode_t              mode_reg, mode_next;
    set_mode_t          set_reg, set_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [3:0]         held_reg, held_next;
    logic               shift_reg, shift_next;
    logic [TIME_W-1:0]  alarm_min_reg, alarm_min_next;
    logic [TIME_W-1:0]  alarm_sec_reg, alarm_sec_next;
    logic               armed_reg, armed_next;
    logic               view_reg, view_next, view_final;
    logic               blink_reg, blink_next, blink_final;
    logic               match;

    logic       is_digit, is_letter, in_entry;
    logic [7:0] hi_val, lo_val;
    logic       out_of_range;

    assign is_digit  = (item.key_code >= KEY_ZERO) && (item.key_code <= KEY_NINE);
    assign is_letter = (item.key_code >= KEY_A) && (item.key_code <= KEY_E);
    assign in_entry  = (mode_reg == MODE_CLEAR) || (mode_reg == MODE_SET_TIME) ||
                       (mode_reg == MODE_SET_ALARM);

    // tens digit times ten plus units digit, each digit 0 to 9
    assign hi_val = {1'b0, entry_reg[15:12], 3'b000} + {3'b000, entry_reg[15:12], 1'b0}
                  + {4'b0000, entry_reg[11:8]};
    assign lo_val = {1'b0, entry_reg[7:4], 3'b000} + {3'b000, entry_reg[7:4], 1'b0}
                  + {4'b0000, entry_reg[3:0]};
    assign out_of_range = (hi_val > TIME_MAX) || (lo_val > TIME_MAX);

    always_comb begin
        mode_next      = mode_reg;
        set_next       = set_reg;
        entry_next     = entry_reg;
        held_next      = held_reg;
        shift_next     = shift_reg;
        alarm_min_next = alarm_min_reg;
        alarm_sec_next = alarm_sec_reg;
        armed_next     = armed_reg;
        view_next      = view_reg;
        blink_next     = blink_reg;
        time_load      = '0;

        if (item.key && (is_digit || is_letter)) begin
            if (is_digit) begin
                shift_next = 1'b1;
                held_next  = item.key_code[3:0];
            end else if (in_entry) begin
                if (item.key_code == KEY_A) begin
                    mode_next  = MODE_COMMIT;
                    shift_next = 1'b0;
                end else if (item.key_code == KEY_B) begin
                    mode_next  = MODE_CLEAR;
                    shift_next = 1'b1;
                end else begin
                    shift_next = 1'b0;
                end
            end else begin
                if (item.key_code == KEY_C) begin
                    mode_next  = MODE_TOGGLE;
                    shift_next = 1'b0;
                end else if (item.key_code == KEY_D) begin
                    mode_next  = MODE_SET_TIME;
                    shift_next = 1'b0;
                end else if (item.key_code == KEY_E) begin
                    mode_next  = MODE_SET_ALARM;
                    shift_next = 1'b0;
                end
            end

            case (mode_next)
                MODE_COMMIT: begin
                    if (set_reg == SET_ALARM) begin
                        alarm_min_next = out_of_range ? '0 : hi_val[TIME_W-1:0];
                        alarm_sec_next = out_of_range ? '0 : lo_val[TIME_W-1:0];
                        armed_next     = 1'b1;
                    end else if (set_reg == SET_TIME) begin
                        time_load.load    = 1'b1;
                        time_load.minutes = out_of_range ? '0 : hi_val[TIME_W-1:0];
                        time_load.seconds = out_of_range ? '0 : lo_val[TIME_W-1:0];
                    end
                    entry_next = '0;
                    set_next   = SET_IDLE;
                end
                MODE_CLEAR: begin
                    entry_next = '0;
                    mode_next  = mode_t'({1'b0, set_reg} + 3'd3);
                end
                MODE_TOGGLE: begin
                    armed_next = ~armed_reg;
                    view_next  = 1'b0;
                    blink_next = 1'b0;
                end
                MODE_SET_TIME: begin
                    set_next = SET_TIME;
                    if (shift_next) begin
                        entry_next = {entry_reg[11:0], held_next};
                    end
                end
                MODE_SET_ALARM: begin
                    set_next = SET_ALARM;
                    if (shift_next) begin
                        entry_next = {entry_reg[11:0], held_next};
                    end
                end
                default: begin
                end
            endcase

            case (set_next)
                SET_IDLE: begin
                    blink_next = 1'b0;
                    view_next  = 1'b0;
                end
                SET_TIME: begin
                    blink_next = 1'b0;
                    view_next  = 1'b1;
                end
                SET_ALARM: begin
                    blink_next = 1'b1;
                    view_next  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // armed alarm at the clock time forces the clock view and blink
    always_comb begin
        match = (item.tick || item.key) && armed_next &&
                (alarm_min_next == clock_next.minutes) &&
                (alarm_sec_next == clock_next.seconds);
        view_final  = match ? 1'b0 : view_next;
        blink_final = match ? 1'b1 : blink_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            set_reg       <= SET_IDLE;
            entry_reg     <= '0;
            held_reg      <= '0;
            shift_reg     <= 1'b0;
            alarm_min_reg <= '0;
            alarm_sec_reg <= '0;
            armed_reg     <= 1'b0;
            view_reg      <= 1'b0;
            blink_reg     <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            set_reg       <= set_next;
            entry_reg     <= entry_next;
            held_reg      <= held_next;
            shift_reg     <= shift_next;
            alarm_min_reg <= alarm_min_next;
            alarm_sec_reg <= alarm_sec_next;
            armed_reg     <= armed_next;
            view_reg      <= view_final;
            blink_reg     <= blink_final;
        end
    end

    assign panel_next.match      = match;
    assign panel_next.armed      = armed_next;
    assign panel_next.blink      = blink_final;
    assign panel_next.show_entry = view_final;
    assign panel_next.entry      = entry_next;

endmodule
`default_nettype wire

// ----- rtl/keypad_alarm_clock_controller_top.sv -----
// Top level of the keypad alarm clock controller: input register, rate register,
// result register. Depends on kacc_pkg, kacc_clock and kacc_keypad.
//
//  channel  direction  accepted when             payload
//  s_       in         s_tvalid && s_tready      tuser: func, tdata: key_code
//  m_       out        m_tvalid && m_tready      tdata: one result per item
//  cfg_     in         cfg_valid && cfg_ready    cfg_data: ticks_per_second
//
// One item per cycle sustained while results are taken; each item waits in the input register
// and its result is then written to the result register; a stall can hold it in the input register.
// The state update is a single pass through the keypad and clock logic.
// Reset is synchronous; afterwards the rate register reads 200 and all clock and keypad state is zero.
// A stalled result holds the result register, and one further item waits in the input
// register; s_tready drops only while both are full.
`default_nettype none
module keypad_alarm_clock_controller_top (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [kacc_pkg::KEY_W-1:0]     s_tdata,   // [7:0] key_code
    input  wire  [0:0]                     s_tuser,   // [0] func
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // [5:0] clock_minutes, [11:6] clock_seconds, [27:12] entry_digits,
    // [28] show_entry, [29] blink, [30] alarm_enabled, [31] alarm_match
    output logic [kacc_pkg::RESULT_W-1:0]  m_tdata,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [kacc_pkg::TICK_W-1:0]    cfg_data
);
    import kacc_pkg::*;

    logic               in_valid_reg;
    logic [KEY_W-1:0]   in_key_reg;
    logic               in_func_reg;
    logic               out_valid_reg;
    logic [RESULT_W-1:0] out_data_reg;
    logic [TICK_W-1:0]  tps_reg;
    logic               process;

    item_ctl_t   item;
    time_load_t  time_load;
    clock_view_t clock_next;
    panel_view_t panel_next;

    assign process   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || process;
    assign cfg_ready = 1'b1;

    assign item.tick     = process && (in_func_reg == FUNC_TICK);
    assign item.key      = process && (in_func_reg == FUNC_KEY);
    assign item.key_code = in_key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tps_reg       <= RESET_TICKS;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (process) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                tps_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_key_reg  <= s_tdata;
            in_func_reg <= s_tuser[0];
        end
        if (process) begin
            out_data_reg <= {panel_next.match, panel_next.armed, panel_next.blink,
                             panel_next.show_entry, panel_next.entry,
                             clock_next.seconds, clock_next.minutes};
        end
    end

    kacc_clock u_clock (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item             (item),
        .ticks_per_second (tps_reg),
        .time_load        (time_load),
        .clock_next       (clock_next)
    );

    kacc_keypad u_keypad (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (item),
        .clock_next (clock_next),
        .time_load  (time_load),
        .panel_next (panel_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] <= 6'd59) && (m_tdata[11:6] <= 6'd59))
        else $error("clock time out of range");

    a_match_view: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[31]) |-> (m_tdata[30] && m_tdata[29] && !m_tdata[28]))
        else $error("alarm match without armed alarm, blink and clock view");

    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !process) |=> in_valid_reg)
        else $error("waiting item dropped");

    a_result_on_process: assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> m_tvalid)
        else $error("processed item gave no result");
`endif

endmodule
`default_nettype wire
